// ===== hdl/lstm_cell_three_unit_inference_assert.svh =====
// Assertion macros shared by the LSTM cell RTL.
`ifndef LSTM_CELL_THREE_UNIT_INFERENCE_ASSERT_SVH
`define LSTM_CELL_THREE_UNIT_INFERENCE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LCI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LCI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lci_pkg.sv =====
// Shared types, constants and arithmetic helpers of the LSTM cell.
package lci_pkg;

	localparam int HIDDEN_UNITS_DEF = 3;
	localparam int ACT_DEPTH_DEF    = 256;
	localparam int ACC_W            = 42;

	// Item modes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	// One in Q4.12, used to scale the biases.
	localparam logic signed [15:0] Q12_ONE = 16'sd4096;

	typedef logic signed [ACC_W-1:0] lci_acc_t;

	typedef enum logic [3:0] {
		S_IDLE, S_GATE, S_GDRAIN, S_GACT, S_GWAIT,
		S_CELL_F, S_CELL_G, S_CDRAIN, S_CSTORE, S_CACT, S_CWAIT,
		S_HDRAIN, S_HSTORE, S_OUT, S_ODRAIN, S_OSTORE
	} lci_state_t;

	// Request to the activation unit.
	typedef struct packed {
		logic              start;
		logic              use_tanh;
		logic signed [15:0] x;
	} lci_act_req_t;

	// Response of the activation unit.
	typedef struct packed {
		logic              done;
		logic signed [15:0] y;
	} lci_act_rsp_t;

	// One multiply-accumulate operation, registered before it is applied.
	typedef struct packed {
		logic              valid;
		logic              use_mem;
		logic signed [23:0] a;
		logic signed [15:0] b;
	} lci_mac_op_t;

	// Arithmetic shift right by s with rounding half up.
	function automatic lci_acc_t rnd_sh(input lci_acc_t v, input int unsigned s);
		return (v + (lci_acc_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] sat16(input lci_acc_t v);
		if (v > lci_acc_t'(32767))
			return 16'sh7fff;
		else if (v < lci_acc_t'(-32768))
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input lci_acc_t v);
		if (v > lci_acc_t'(8388607))
			return 24'sh7fffff;
		else if (v < lci_acc_t'(-8388608))
			return 24'sh800000;
		return v[23:0];
	endfunction

	// exp(-8k/D) in Q31 by repeated multiplication with the Q31 ratio r.
	function automatic longint unsigned act_pow(input longint unsigned r, input int k);
		longint unsigned e;
		e = 64'd1 << 31;
		for (int n = 0; n < k; n++)
			e = (e * r) >> 31;
		return e;
	endfunction

endpackage

// ===== hdl/lci_act.sv =====
// Pipelined sigmoid and tanh unit with an interpolated constant table.
module lci_act #(
	parameter int ACT_TABLE_DEPTH = lci_pkg::ACT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lci_pkg::lci_act_req_t req,
	output lci_pkg::lci_act_rsp_t rsp
);
	import lci_pkg::*;

	localparam int D    = ACT_TABLE_DEPTH;
	localparam int IdxW = $clog2(D + 1);
	localparam int PW   = 16 + IdxW;
	localparam logic [IdxW:0] DVal = (IdxW + 1)'(D);

	// Taylor terms of exp(-8/D) in Q31, each truncated from the one before.
	localparam longint unsigned One31 = 64'd1 << 31;
	localparam longint unsigned Tm1  = (One31 * 64'd8) / (64'(D) * 64'd1);
	localparam longint unsigned Tm2  = (Tm1 * 64'd8) / (64'(D) * 64'd2);
	localparam longint unsigned Tm3  = (Tm2 * 64'd8) / (64'(D) * 64'd3);
	localparam longint unsigned Tm4  = (Tm3 * 64'd8) / (64'(D) * 64'd4);
	localparam longint unsigned Tm5  = (Tm4 * 64'd8) / (64'(D) * 64'd5);
	localparam longint unsigned Tm6  = (Tm5 * 64'd8) / (64'(D) * 64'd6);
	localparam longint unsigned Tm7  = (Tm6 * 64'd8) / (64'(D) * 64'd7);
	localparam longint unsigned Tm8  = (Tm7 * 64'd8) / (64'(D) * 64'd8);
	localparam longint unsigned Tm9  = (Tm8 * 64'd8) / (64'(D) * 64'd9);
	localparam longint unsigned Tm10 = (Tm9 * 64'd8) / (64'(D) * 64'd10);
	localparam longint unsigned Tm11 = (Tm10 * 64'd8) / (64'(D) * 64'd11);
	localparam longint unsigned Tm12 = (Tm11 * 64'd8) / (64'(D) * 64'd12);
	localparam longint unsigned RQ = One31 - Tm1 + Tm2 - Tm3 + Tm4 - Tm5 + Tm6
		- Tm7 + Tm8 - Tm9 + Tm10 - Tm11 + Tm12;

	// Sigmoid table in Q1.15, one entry per step of 8/D.
	logic [15:0] act_tab [0:D];

	for (genvar k = 0; k <= D; k++) begin : g_tab
		localparam longint unsigned Ek  = act_pow(RQ, k);
		localparam longint unsigned Den = One31 + Ek;
		localparam longint unsigned Ent = ((64'd1 << 46) + Den / 64'd2) / Den;
		assign act_tab[k] = 16'(Ent);
	end

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic              th_s1, th_s2, th_s3, th_s4;
	logic [15:0]       a_s1;
	logic [IdxW-1:0]   idx_s2;
	logic [14:0]       frac_s2, frac_s3;
	logic [15:0]       t0_s3, t0_s4;
	logic signed [16:0] d_s3;
	logic signed [32:0] prod_s4;
	logic signed [15:0] y_s5;

	logic signed [15:0] xs;
	logic [PW-1:0]      p;
	logic [IdxW:0]      idx_raw;
	logic [IdxW-1:0]    idx_nxt;
	logic [IdxW-1:0]    idx_c;
	logic [14:0]        frac_c;
	logic signed [33:0] pr_rnd;
	logic signed [17:0] v_full;
	logic [16:0]        sv;
	logic [17:0]        tw;
	logic signed [15:0] y_c;

	// Stage 1 input: tanh works on sigmoid of twice the argument.
	always_comb begin
		xs = req.use_tanh ? sat16(lci_acc_t'(signed'({req.x, 1'b0}))) : req.x;
	end

	// Stage 2 input: table position and fraction, clamped at the table end.
	always_comb begin
		p       = PW'(a_s1) * PW'(D);
		idx_raw = p[PW-1:15];
		if (idx_raw >= DVal) begin
			idx_c  = IdxW'(D);
			frac_c = '0;
		end else begin
			idx_c  = idx_raw[IdxW-1:0];
			frac_c = p[14:0];
		end
	end

	// Stage 3 input: neighbouring entry for interpolation.
	always_comb begin
		idx_nxt = (idx_s2 < IdxW'(D)) ? idx_s2 + 1'b1 : idx_s2;
	end

	// Stage 5 input: rounded interpolation, mirror for negative arguments.
	always_comb begin
		pr_rnd = 34'(prod_s4) + 34'sd16384;
		v_full = 18'(signed'({2'b00, t0_s4})) + 18'(pr_rnd >>> 15);
		sv     = neg_s4 ? 17'd32768 - {1'b0, v_full[15:0]} : {1'b0, v_full[15:0]};
		tw     = (({1'b0, sv} << 1) + 18'd4) >> 3;
		if (th_s4)
			y_c = 16'(tw) - 16'sd4096;
		else
			y_c = 16'((sv + 17'd4) >> 3);
	end

	// Valid flags of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Data path of the pipeline.
	always_ff @(posedge clk) begin
		a_s1    <= (xs < 0) ? 16'(-17'(xs)) : 16'(xs);
		neg_s1  <= xs < 0;
		th_s1   <= req.use_tanh;
		idx_s2  <= idx_c;
		frac_s2 <= frac_c;
		neg_s2  <= neg_s1;
		th_s2   <= th_s1;
		t0_s3   <= act_tab[idx_s2];
		d_s3    <= signed'({1'b0, act_tab[idx_nxt]}) - signed'({1'b0, act_tab[idx_s2]});
		frac_s3 <= frac_s2;
		neg_s3  <= neg_s2;
		th_s3   <= th_s2;
		prod_s4 <= d_s3 * signed'({1'b0, frac_s3});
		t0_s4   <= t0_s3;
		neg_s4  <= neg_s3;
		th_s4   <= th_s3;
		y_s5    <= y_c;
	end

	assign rsp.done = v_s5;
	assign rsp.y    = y_s5;

endmodule

// ===== hdl/lstm_cell_three_unit_inference.sv =====
// Single-input LSTM cell with H hidden units and one linear output, top level.
//
// The item channel (item_valid/item_ready) carries one word per item. A word
// with mode 0 writes weight_value into the weight memory at weight_index and
// produces no result; it is taken while the block is idle. A word with mode 1
// runs one LSTM time step on sample and produces one word on the result
// channel (result_valid/result_ready) carrying prediction.
// All weights must be written before the first sample.
// Every multiply-accumulate goes through one shared multiplier fed from the
// weight memory, which has a registered read port, or from the gate and cell
// registers, and each activation passes through the pipelined table unit.
// One sample is worked on at a time; the next word can be taken from the
// cycle after the result is loaded. A finished result sits in an output
// register while the block returns to idle and goes on taking words. If the
// next sample reaches its final write-back before the receiver takes the
// waiting result, the sequencer holds there and the item channel stays closed
// until the result is taken. Reset clears hidden and cell state and the result
// register valid flag; the weight memory keeps no reset value.
`include "lstm_cell_three_unit_inference_assert.svh"

module lstm_cell_three_unit_inference #(
	parameter int HIDDEN_UNITS    = lci_pkg::HIDDEN_UNITS_DEF,
	parameter int ACT_TABLE_DEPTH = lci_pkg::ACT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              mode,
	input  logic [5:0]        weight_index,
	input  logic signed [15:0] weight_value,
	input  logic signed [15:0] sample,
	output logic              result_valid,
	input  logic              result_ready,
	output logic signed [15:0] prediction
);
	import lci_pkg::*;

	localparam int H           = HIDDEN_UNITS;
	localparam int OfsRec      = 4 * H;
	localparam int OfsBias     = OfsRec + 4 * H * H;
	localparam int OfsOutw     = OfsBias + 4 * H;
	localparam int OfsOutb     = OfsOutw + H;
	localparam int WeightCount = OfsOutb + 1;
	localparam int AddrW       = $clog2(WeightCount);
	localparam int RowW        = $clog2(4 * H);
	localparam int TermW       = $clog2(H + 2);
	localparam int JW          = $clog2(H + 1);
	localparam int HIdxW       = (H > 1) ? $clog2(H) : 1;

	localparam logic [RowW-1:0]  LastRow      = RowW'(4 * H - 1);
	localparam logic [RowW-1:0]  FirstTanhRow = RowW'(3 * H);
	localparam logic [TermW-1:0] LastGateTerm = TermW'(H + 1);
	localparam logic [TermW-1:0] LastRecTerm  = TermW'(H);
	localparam logic [TermW-1:0] LastOutTerm  = TermW'(H);
	localparam logic [JW-1:0]    LastJ        = JW'(H - 1);

	lci_state_t state_q, state_d;

	logic [RowW-1:0]    row_q;
	logic [TermW-1:0]   term_q;
	logic [JW-1:0]      j_q;
	logic signed [15:0] x_q;
	logic signed [15:0] h_q    [0:H-1];
	logic signed [23:0] c_q    [0:H-1];
	logic signed [15:0] gate_q [0:4*H-1];
	lci_acc_t           acc_q;
	lci_mac_op_t        op_s1, op_d;
	logic signed [15:0] res_q;
	logic               res_valid_q;

	logic [15:0]        wmem [0:WeightCount-1];
	logic [15:0]        rd_s1;
	logic [AddrW-1:0]   rd_addr;
	logic [AddrW-1:0]   wr_addr;
	logic               wr_en;

	lci_act_req_t act_req;
	lci_act_rsp_t act_rsp;

	logic               accept;
	logic               acc_clr;
	logic               out_fire;
	logic [TermW-1:0]   tm1;
	logic [HIdxW-1:0]   hsel;
	logic [HIdxW-1:0]   jsel;
	logic [RowW-1:0]    i_idx, f_idx, o_idx, g_idx;
	logic signed [15:0] pre_q12;
	logic signed [23:0] cnew;
	logic signed [15:0] cq4;
	logic signed [23:0] a_eff;
	logic signed [39:0] prod;

	// Handshake and write port of the weight memory.
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign wr_en      = accept && (mode == MODE_LOAD) && (int'(weight_index) < WeightCount);
	assign wr_addr    = AddrW'(weight_index);
	assign out_fire   = !res_valid_q || result_ready;

	// Index helpers and narrowing of the accumulator.
	always_comb begin
		tm1     = term_q - 1'b1;
		hsel    = tm1[HIdxW-1:0];
		jsel    = j_q[HIdxW-1:0];
		i_idx   = RowW'(int'(j_q));
		f_idx   = RowW'(H + int'(j_q));
		o_idx   = RowW'(2 * H + int'(j_q));
		g_idx   = RowW'(3 * H + int'(j_q));
		pre_q12 = sat16(rnd_sh(acc_q, 12));
		cnew    = sat24(rnd_sh(acc_q, 12));
		cq4     = sat16(rnd_sh(lci_acc_t'(c_q[jsel]), 4));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept && mode == MODE_RUN) state_d = S_GATE;
			S_GATE:   if (term_q == LastGateTerm) state_d = S_GDRAIN;
			S_GDRAIN: state_d = S_GACT;
			S_GACT:   state_d = S_GWAIT;
			S_GWAIT: begin
				if (act_rsp.done)
					state_d = (row_q == LastRow) ? S_CELL_F : S_GATE;
			end
			S_CELL_F: state_d = S_CELL_G;
			S_CELL_G: state_d = S_CDRAIN;
			S_CDRAIN: state_d = S_CSTORE;
			S_CSTORE: state_d = S_CACT;
			S_CACT:   state_d = S_CWAIT;
			S_CWAIT:  if (act_rsp.done) state_d = S_HDRAIN;
			S_HDRAIN: state_d = S_HSTORE;
			S_HSTORE: state_d = (j_q == LastJ) ? S_OUT : S_CELL_F;
			S_OUT:    if (term_q == LastOutTerm) state_d = S_ODRAIN;
			S_ODRAIN: state_d = S_OSTORE;
			S_OSTORE: if (out_fire) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory reads, operations for the multiplier and activation requests.
	always_comb begin
		rd_addr = '0;
		op_d    = '0;
		act_req = '0;
		acc_clr = 1'b0;
		unique case (state_q) inside
			S_IDLE: acc_clr = accept;
			S_GATE: begin
				op_d.valid   = 1'b1;
				op_d.use_mem = 1'b1;
				if (term_q == '0) begin
					rd_addr = AddrW'(int'(row_q));
					op_d.b  = x_q;
				end else if (term_q <= LastRecTerm) begin
					rd_addr = AddrW'(OfsRec + int'(row_q) * H + int'(tm1));
					op_d.b  = h_q[hsel];
				end else begin
					rd_addr = AddrW'(OfsBias + int'(row_q));
					op_d.b  = Q12_ONE;
				end
			end
			S_GACT: begin
				act_req.start    = 1'b1;
				act_req.use_tanh = (row_q >= FirstTanhRow);
				act_req.x        = pre_q12;
			end
			S_GWAIT: acc_clr = act_rsp.done;
			S_CELL_F: begin
				op_d.valid = 1'b1;
				op_d.a     = c_q[jsel];
				op_d.b     = gate_q[f_idx];
			end
			S_CELL_G: begin
				// Candidate times sixteen brings the product to Q12.28.
				op_d.valid = 1'b1;
				op_d.a     = {{4{gate_q[g_idx][15]}}, gate_q[g_idx], 4'b0000};
				op_d.b     = gate_q[i_idx];
			end
			S_CSTORE: acc_clr = 1'b1;
			S_CACT: begin
				act_req.start    = 1'b1;
				act_req.use_tanh = 1'b1;
				act_req.x        = cq4;
			end
			S_CWAIT: begin
				if (act_rsp.done) begin
					op_d.valid = 1'b1;
					op_d.a     = 24'(act_rsp.y);
					op_d.b     = gate_q[o_idx];
				end
			end
			S_HSTORE: acc_clr = 1'b1;
			S_OUT: begin
				op_d.valid   = 1'b1;
				op_d.use_mem = 1'b1;
				if (term_q == '0) begin
					rd_addr = AddrW'(OfsOutb);
					op_d.b  = Q12_ONE;
				end else begin
					rd_addr = AddrW'(OfsOutw + int'(tm1));
					op_d.b  = h_q[hsel];
				end
			end
			S_OSTORE: acc_clr = out_fire;
			S_GDRAIN, S_CDRAIN, S_HDRAIN, S_ODRAIN: acc_clr = 1'b0;
			default: acc_clr = 1'b0;
		endcase
	end

	// Weight memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			wmem[wr_addr] <= weight_value;
		rd_s1 <= wmem[rd_addr];
	end

	// Shared multiply-accumulate.
	always_comb begin
		a_eff = op_s1.use_mem ? 24'(signed'(rd_s1)) : op_s1.a;
		prod  = a_eff * op_s1.b;
	end

	// Control state, counters, hidden and cell state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			term_q      <= '0;
			j_q         <= '0;
			op_s1       <= '0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < H; k++) begin
				h_q[k] <= '0;
				c_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			op_s1   <= op_d;
			if (accept && mode == MODE_RUN) begin
				row_q  <= '0;
				term_q <= '0;
				j_q    <= '0;
			end
			if (state_q == S_GATE)
				term_q <= (term_q == LastGateTerm) ? '0 : term_q + 1'b1;
			if (state_q == S_OUT)
				term_q <= (term_q == LastOutTerm) ? '0 : term_q + 1'b1;
			if (state_q == S_GWAIT && act_rsp.done)
				row_q <= (row_q == LastRow) ? '0 : row_q + 1'b1;
			if (state_q == S_CSTORE)
				c_q[jsel] <= cnew;
			if (state_q == S_HSTORE) begin
				h_q[jsel] <= pre_q12;
				j_q       <= (j_q == LastJ) ? '0 : j_q + 1'b1;
			end
			if (state_q == S_OSTORE && out_fire)
				res_valid_q <= 1'b1;
			else if (result_valid && result_ready)
				res_valid_q <= 1'b0;
		end
	end

	// Sample, gate values, accumulator and result word.
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_RUN)
			x_q <= sample;
		if (state_q == S_GWAIT && act_rsp.done)
			gate_q[row_q] <= act_rsp.y;
		if (acc_clr)
			acc_q <= '0;
		else if (op_s1.valid)
			acc_q <= acc_q + lci_acc_t'(prod);
		if (state_q == S_OSTORE && out_fire)
			res_q <= pre_q12;
	end

	lci_act #(
		.ACT_TABLE_DEPTH(ACT_TABLE_DEPTH)
	) u_act (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (act_req),
		.rsp    (act_rsp)
	);

	assign result_valid = res_valid_q;
	assign prediction   = res_q;

	// A sample word starts the gate sweep at once.
	`LCI_ASSERT_NEXT(a_run_starts, accept && mode == MODE_RUN, state_q == S_GATE, "sample not started")
	// Each gate row starts from a cleared accumulator.
	`LCI_ASSERT_SAME(a_acc_clear, state_q == S_GATE && term_q == '0, acc_q == '0, "accumulator not cleared")
	// The activation unit answers only while the sequencer waits for it.
	`LCI_ASSERT_SAME(a_act_expected, act_rsp.done, state_q == S_GWAIT || state_q == S_CWAIT, "stray activation")
	// A result appears only from the final write-back.
	`LCI_ASSERT_SAME(a_res_source, $rose(result_valid), $past(state_q == S_OSTORE), "stray result")

endmodule
